### sv/crsfp_pkg.sv
package crsfp_pkg;

    localparam int MAX_PACKET = 64;
    localparam int ADDR_W = $clog2(MAX_PACKET);
    localparam int CNT_W = ADDR_W + 1;

    // Configuration register indexes.
    localparam logic [7:0] REG_CRC_POLY = 8'd0;
    localparam logic [7:0] REG_EXT_MIN  = 8'd1;
    localparam logic [7:0] REG_MIN_LEN  = 8'd2;
    localparam logic [7:0] REG_MAX_LEN  = 8'd3;

    // Control that every cell of the byte chain sees.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // One byte of an MSB-first CRC-8 with zero initial value.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/crsfp_cell.sv
module crsfp_cell (
    input  logic                  i_clk,
    input  crsfp_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_next,
    output logic [7:0]            o_byte
);
    import crsfp_pkg::*;

    logic [7:0] r_byte;

    // A load takes the new byte; a shift takes the neighbor's byte.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;
endmodule

### sv/crsf_frame_parser_resync_top.sv
// A byte that completes a frame is resynced one byte per cycle, then the frame check
// makes one full rotation of the 64-cell byte chain.
// A new byte is taken only in idle: a failed check is followed by a tail drop, a passing
// one by a header skip, the result transactions and a tail drop.
// Reset (synchronous, active low) empties the buffer and restores register defaults.
module crsf_frame_parser_resync_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // device_address, frame_type, destination, source, payload_length,
    // payload_index, payload_byte, zero pad
    output logic [55:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // is_extended, has_payload
    output logic        o_m_tlast
);
    import crsfp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SYNC  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_DROP  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_poly, r_ext_min;
    logic [5:0]       r_min_len, r_max_len;
    logic [7:0]       r_addr, r_type, r_dest, r_src, n_addr, n_type, n_dest, n_src;
    logic             r_ext, n_ext, r_ok, n_ok;
    logic [5:0]       r_len, n_len, r_plen, n_plen, r_idx, n_idx;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [7:0]       r_crc, n_crc;
    logic [2:0]       r_drop, n_drop;
    logic             w_shift, w_append, w_full, w_s_acc, w_m_acc, w_last, w_cur_ext;
    logic [7:0]       w_bytes [MAX_PACKET];
    logic [CNT_W-1:0] w_size;

    assign w_s_acc = i_s_tvalid && o_s_tready;
    assign w_m_acc = o_m_tvalid && i_m_tready;
    assign w_full = (r_cnt == CNT_W'(MAX_PACKET));
    assign w_append = w_s_acc;
    assign w_size = CNT_W'(w_bytes[1]) + CNT_W'(2);
    assign w_cur_ext = (w_bytes[2] >= r_ext_min);
    assign w_last = (r_plen == 6'd0) || (r_idx == r_plen - 6'd1);

    // Byte chain; cell 0 is the oldest byte and the last cell wraps to cell 0.
    for (genvar g = 0; g < MAX_PACKET; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.shift = w_shift || (w_append && w_full);
        assign w_ctl.load = w_append && (w_full ? (g == MAX_PACKET - 1)
                                                : (r_cnt[ADDR_W-1:0] == ADDR_W'(g)));
        crsfp_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_byte (i_s_tdata),
            .i_next (w_bytes[(g + 1) % MAX_PACKET]),
            .o_byte (w_bytes[g])
        );
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= 8'd213;
            r_ext_min <= 8'd40;
            r_min_len <= 6'd2;
            r_max_len <= 6'd62;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CRC_POLY: r_poly <= i_cfg_data;
                REG_EXT_MIN:  r_ext_min <= i_cfg_data;
                REG_MIN_LEN:  r_min_len <= i_cfg_data[5:0];
                REG_MAX_LEN:  r_max_len <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Sequencer: resync, CRC rotation, header skip, result run and tail drop.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_addr = r_addr;
        n_type = r_type;
        n_dest = r_dest;
        n_src = r_src;
        n_ext = r_ext;
        n_ok = r_ok;
        n_len = r_len;
        n_plen = r_plen;
        n_idx = r_idx;
        n_k = r_k;
        n_crc = r_crc;
        n_drop = r_drop;
        w_shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    if (!w_full) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (r_cnt < CNT_W'(2)) begin
                    n_state = ST_IDLE;
                end else if (w_bytes[1] < 8'(r_min_len) || w_bytes[1] > 8'(r_max_len)) begin
                    w_shift = 1'b1;
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (r_cnt < w_size) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = w_bytes[0];
                    n_type = w_bytes[2];
                    n_ext = w_cur_ext;
                    n_dest = w_cur_ext ? w_bytes[3] : 8'd0;
                    n_src = w_cur_ext ? w_bytes[4] : 8'd0;
                    n_len = w_bytes[1][5:0];
                    n_plen = w_bytes[1][5:0] - (w_cur_ext ? 6'd4 : 6'd2);
                    n_drop = w_cur_ext ? 3'd5 : 3'd3;
                    n_idx = 6'd0;
                    n_k = '0;
                    n_crc = 8'd0;
                    n_ok = 1'b0;
                    // A short frame fails at once, like a CRC error.
                    if (w_bytes[1] < (w_cur_ext ? 8'd4 : 8'd2)) begin
                        n_state = ST_DROP;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // Cell 2 shows the byte k positions after the type byte.
                w_shift = 1'b1;
                n_k = r_k + ADDR_W'(1);
                if (6'(r_k) < r_len - 6'd1) begin
                    n_crc = crc8_byte(r_crc, w_bytes[2], r_poly);
                end else if (6'(r_k) == r_len - 6'd1) begin
                    n_ok = (w_bytes[2] == r_crc);
                end
                if (r_k == ADDR_W'(MAX_PACKET - 1)) begin
                    n_state = n_ok ? ST_HEAD : ST_DROP;
                end
            end
            ST_HEAD: begin
                w_shift = 1'b1;
                n_cnt = r_cnt - CNT_W'(1);
                n_drop = r_drop - 3'd1;
                if (r_drop == 3'd1) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_m_acc) begin
                    if (r_plen != 6'd0) begin
                        w_shift = 1'b1;
                        n_cnt = r_cnt - CNT_W'(1);
                        n_idx = r_idx + 6'd1;
                    end
                    if (w_last) begin
                        n_state = ST_DROP;
                    end
                end
            end
            ST_DROP: begin
                w_shift = 1'b1;
                n_cnt = r_cnt - CNT_W'(1);
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_type <= n_type;
        r_dest <= n_dest;
        r_src <= n_src;
        r_ext <= n_ext;
        r_ok <= n_ok;
        r_len <= n_len;
        r_plen <= n_plen;
        r_idx <= n_idx;
        r_k <= n_k;
        r_crc <= n_crc;
        r_drop <= n_drop;
    end

    // Result fields come straight from registers and the head cell.
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_EMIT);
    assign o_m_tdata = {4'd0, (r_plen != 6'd0) ? w_bytes[0] : 8'd0, r_idx, r_plen,
                        r_src, r_dest, r_type, r_addr};
    assign o_m_tuser = {(r_plen != 6'd0), r_ext};
    assign o_m_tlast = w_last;

    // The buffer never holds more than its capacity.
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PACKET)) else $error("buffer count overflow");

    // Input and output are never open at the same time.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("input and output both active");

    // An accepted byte is always followed by a resync pass.
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == ST_SYNC)) else $error("no resync after byte");

endmodule
